@@ hdl/linear_probe_hash_map_unit_assert.svh @@
// assertion macros for the linear probe hash map unit
`ifndef LINEAR_PROBE_HASH_MAP_UNIT_ASSERT_SVH
`define LINEAR_PROBE_HASH_MAP_UNIT_ASSERT_SVH
// implication checked every clock outside reset
`define LPHM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// implication whose consequent is checked in the next cycle
`define LPHM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ hdl/lphm_pkg.sv @@
// package of types and constants for the linear probe hash map unit
`default_nettype none
package lphm_pkg;
  localparam int unsigned TableSize = 1024;
  localparam int unsigned IdxW = $clog2(TableSize);
  localparam int unsigned KeyW = 31;
  localparam int unsigned ValW = 31;
  localparam int unsigned CntW = $clog2(TableSize + 1);
  localparam int unsigned QDepth = 2;

  typedef enum logic [1:0] {
    OpPut = 2'd0,
    OpGet = 2'd1,
    OpRemove = 2'd2,
    OpNone = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MarkEmpty = 2'd0,
    MarkUsed = 2'd1,
    MarkDeleted = 2'd2
  } mark_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StRead,
    StCheck,
    StWrite,
    StDone
  } state_e;

  typedef struct packed {
    op_e op;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] val;
    logic [IdxW-1:0] home;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic [ValW-1:0] read_value;
    logic status;
  } res_t;

  localparam int unsigned MarkW = 2;
  localparam int unsigned SlotW = MarkW + KeyW + ValW;
endpackage
`default_nettype wire

@@ hdl/lphm_ram.sv @@
// generic single port ram with registered read
`default_nettype none
module lphm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

@@ hdl/lphm_front.sv @@
// front end: accepts requests, computes the home slot, queues commands
`default_nettype none
module lphm_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire lphm_pkg::cmd_t in_cmd_i,
  output logic                cmd_valid_o,
  input  wire logic           cmd_ready_i,
  output lphm_pkg::cmd_t      cmd_o
);
  localparam int unsigned PtrW = $clog2(lphm_pkg::QDepth);
  lphm_pkg::cmd_t q_mem_q [lphm_pkg::QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0] cnt_q;
  logic push, pop;
  lphm_pkg::cmd_t cmd_in;

  always_comb begin
    cmd_in = in_cmd_i;
    cmd_in.home = lphm_pkg::IdxW'(in_cmd_i.key % lphm_pkg::TableSize);
  end

  assign in_ready_o = (cnt_q != (PtrW+1)'(lphm_pkg::QDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o = q_mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

@@ hdl/lphm_back.sv @@
// back end: probe sequencer over the slot memory
`default_nettype none
`include "linear_probe_hash_map_unit_assert.svh"
module lphm_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  output logic                cmd_ready_o,
  input  wire lphm_pkg::cmd_t cmd_i,
  output logic                res_valid_o,
  input  wire logic           res_ready_i,
  output lphm_pkg::res_t      res_o
);
  localparam int unsigned IdxW = lphm_pkg::IdxW;
  localparam int unsigned KeyW = lphm_pkg::KeyW;
  localparam int unsigned ValW = lphm_pkg::ValW;
  localparam int unsigned MarkW = lphm_pkg::MarkW;

  lphm_pkg::state_e state_q, state_d;
  lphm_pkg::cmd_t cmd_q, cmd_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic [lphm_pkg::CntW-1:0] n_q, n_d;
  logic has_free_q, has_free_d;
  logic [IdxW-1:0] free_q, free_d;
  lphm_pkg::res_t res_q, res_d;
  logic [IdxW-1:0] wr_addr_q, wr_addr_d;
  logic [lphm_pkg::SlotW-1:0] wr_data_q, wr_data_d;

  logic we;
  logic [IdxW-1:0] addr;
  logic [lphm_pkg::SlotW-1:0] wdata, rdata;
  logic [MarkW-1:0] rmark;
  logic [KeyW-1:0] rkey;
  logic [ValW-1:0] rval;
  logic last_probe;

  assign rmark = rdata[lphm_pkg::SlotW-1 -: MarkW];
  assign rkey = rdata[KeyW+ValW-1 -: KeyW];
  assign rval = rdata[ValW-1:0];
  assign last_probe = (n_q == lphm_pkg::CntW'(lphm_pkg::TableSize - 1));

  lphm_ram #(.Width(lphm_pkg::SlotW), .Depth(lphm_pkg::TableSize)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d = state_q;
    cmd_d = cmd_q;
    pos_d = pos_q;
    n_d = n_q;
    has_free_d = has_free_q;
    free_d = free_q;
    res_d = res_q;
    wr_addr_d = wr_addr_q;
    wr_data_d = wr_data_q;
    we = 1'b0;
    addr = pos_q;
    wdata = wr_data_q;
    cmd_ready_o = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      lphm_pkg::StClear: begin
        we = 1'b1;
        wdata = '0;
        pos_d = pos_q + 1'b1;
        if (pos_q == IdxW'(lphm_pkg::TableSize - 1)) state_d = lphm_pkg::StIdle;
      end
      lphm_pkg::StIdle: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          pos_d = cmd_i.home;
          n_d = '0;
          has_free_d = 1'b0;
          res_d = '0;
          state_d = (cmd_i.op == lphm_pkg::OpNone) ? lphm_pkg::StDone : lphm_pkg::StRead;
        end
      end
      lphm_pkg::StRead: begin
        state_d = lphm_pkg::StCheck;
      end
      lphm_pkg::StCheck: begin
        state_d = lphm_pkg::StDone;
        if (rmark == MarkW'(lphm_pkg::MarkEmpty)) begin
          if (cmd_q.op == lphm_pkg::OpPut) begin
            wr_addr_d = has_free_q ? free_q : pos_q;
            wr_data_d = {MarkW'(lphm_pkg::MarkUsed), cmd_q.key, cmd_q.val};
            state_d = lphm_pkg::StWrite;
          end
        end else if (rmark == MarkW'(lphm_pkg::MarkUsed) && rkey == cmd_q.key) begin
          wr_addr_d = pos_q;
          unique case (cmd_q.op)
            lphm_pkg::OpPut: begin
              wr_data_d = {MarkW'(lphm_pkg::MarkUsed), cmd_q.key, cmd_q.val};
              state_d = lphm_pkg::StWrite;
            end
            lphm_pkg::OpGet: begin
              res_d.found = 1'b1;
              res_d.read_value = rval;
            end
            lphm_pkg::OpRemove: begin
              res_d.found = 1'b1;
              wr_data_d = {MarkW'(lphm_pkg::MarkDeleted), rkey, rval};
              state_d = lphm_pkg::StWrite;
            end
            default: ;
          endcase
        end else begin
          if (rmark != MarkW'(lphm_pkg::MarkUsed) && !has_free_q) begin
            has_free_d = 1'b1;
            free_d = pos_q;
          end
          if (last_probe) begin
            if (cmd_q.op == lphm_pkg::OpPut) begin
              if (has_free_d) begin
                wr_addr_d = has_free_q ? free_q : pos_q;
                wr_data_d = {MarkW'(lphm_pkg::MarkUsed), cmd_q.key, cmd_q.val};
                state_d = lphm_pkg::StWrite;
              end else begin
                res_d.status = 1'b1;
              end
            end
          end else begin
            // wraparound: table size is a power of two here
            pos_d = (pos_q == IdxW'(lphm_pkg::TableSize - 1)) ? '0 : pos_q + 1'b1;
            n_d = n_q + 1'b1;
            state_d = lphm_pkg::StRead;
          end
        end
      end
      lphm_pkg::StWrite: begin
        we = 1'b1;
        addr = wr_addr_q;
        state_d = lphm_pkg::StDone;
      end
      lphm_pkg::StDone: begin
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = lphm_pkg::StIdle;
      end
      default: state_d = lphm_pkg::StIdle;
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lphm_pkg::StClear;
      pos_q <= '0;
    end else begin
      state_q <= state_d;
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    n_q <= n_d;
    has_free_q <= has_free_d;
    free_q <= free_d;
    res_q <= res_d;
    wr_addr_q <= wr_addr_d;
    wr_data_q <= wr_data_d;
  end

  `LPHM_ASSERT_IMP(a_ready_idle, cmd_ready_o, state_q == lphm_pkg::StIdle, "ready outside idle")
  `LPHM_ASSERT_NEXT(a_res_hold, res_valid_o && !res_ready_i, res_valid_o && $stable(res_o),
    "result dropped")
  `LPHM_ASSERT_IMP(a_put_nofound, res_valid_o && cmd_q.op == lphm_pkg::OpPut, !res_o.found,
    "put reports found")
  `LPHM_ASSERT_IMP(a_status_put, res_valid_o && res_o.status, cmd_q.op == lphm_pkg::OpPut,
    "status on non put")
endmodule
`default_nettype wire

@@ hdl/linear_probe_hash_map_unit.sv @@
// linear probe hash map unit: top level joining front queue and probe engine
// throughput: one item at a time in the probe engine, next item taken after the result
// handshake; each probe passes through a memory read state and a compare state
// reset: asynchronous active low; afterward a clearing pass writes every slot empty,
// during which no item leaves the queue
`default_nettype none
module linear_probe_hash_map_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: req_type [1:0], key [32:2], value [63:33]
  input  wire logic [63:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: found [0], read_value [31:1], status [32], zero fill [39:33]
  output logic      [39:0] m_axis_tdata
);
  lphm_pkg::cmd_t in_cmd, cmd;
  lphm_pkg::res_t res;
  logic cmd_valid, cmd_ready;

  // unpack request fields; home slot filled in by the front end
  always_comb begin
    in_cmd.op = lphm_pkg::op_e'(s_axis_tdata[1:0]);
    in_cmd.key = s_axis_tdata[32:2];
    in_cmd.val = s_axis_tdata[63:33];
    in_cmd.home = '0;
  end

  lphm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_cmd_i   (in_cmd),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  // probe engine owns the slot memory and the result register
  lphm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .res_valid_o(m_axis_tvalid),
    .res_ready_i(m_axis_tready),
    .res_o      (res)
  );

  // pack result, lowest field first
  assign m_axis_tdata = {7'd0, res.status, res.read_value, res.found};
endmodule
`default_nettype wire
